[rtl/shcdf_pkg.sv]
// ----------------------------------------------------------------------------
// shcdf_pkg
// Shared types, constants and the byte-wide crc-32 update for the deframer.
// ----------------------------------------------------------------------------
package shcdf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEFAULT = 1024;

  localparam logic [31:0] SYNC_WORD = 32'hC0FFEE77;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;

  localparam logic [3:0] HDR_LAST = 4'd13;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_flags;
    logic [7:0]  modulation;
    logic [7:0]  bandwidth;
    logic [31:0] node_id;
    logic [31:0] sequence_res;
    logic [10:0] payload_length;
  } res_t;

  // reflected crc-32, one byte, eight unrolled shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // crc state after the canonical sync bytes
  localparam logic [31:0] SYNC_CRC =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, 8'hC0), 8'hFF), 8'hEE), 8'h77);

endpackage

[rtl/shcdf_outbuf.sv]
// ----------------------------------------------------------------------------
// shcdf_outbuf
// Result register with a skid stage, so input never waits on an idle output.
// ----------------------------------------------------------------------------
module shcdf_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  shcdf_pkg::res_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output shcdf_pkg::res_t out_data
);
  import shcdf_pkg::*;

  res_t skid;
  logic skid_valid;
  logic take;
  logic slot_free;

  assign take      = out_valid & ~out_stall;
  assign slot_free = take | ~out_valid;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_data <= skid;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

[rtl/sync_hunt_crc32_deframer_core.sv]
// ----------------------------------------------------------------------------
// sync_hunt_crc32_deframer_core
// Sync-word hunting deframer with header capture and a crc-32 frame check.
// ----------------------------------------------------------------------------
// each result word is registered in the output buffer, or held in its skid entry while the output stalls
// throughput: one byte per cycle while in_stall is low, set by the byte-wide crc and the state update
// the two-entry output (register plus skid) lets input flow while a result waits
// synchronous reset returns to hunt with the window cleared, crc at all ones,
// held header fields zero and the output empty
module sync_hunt_crc32_deframer_core #(
  parameter int unsigned MAX_PAYLOAD_BYTES = shcdf_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  frame_flags,
  output logic [7:0]  modulation,
  output logic [7:0]  bandwidth,
  output logic [31:0] node_id,
  output logic [31:0] sequence_res,
  output logic [10:0] payload_length
);
  import shcdf_pkg::*;

  localparam int unsigned PCNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_BYTES);

  phase_t      phase, phase_next;
  logic [31:0] sync_window, sync_window_next;
  logic        inverted_phase, inverted_phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [7:0]  held_mode, held_mode_next;
  logic [7:0]  held_bw, held_bw_next;
  logic [31:0] held_node, held_node_next;
  logic [31:0] held_seq, held_seq_next;
  logic [15:0] held_length, held_length_next;
  logic [PCNT_W-1:0] payload_count, payload_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [23:0] received_crc, received_crc_next;

  logic        accept;
  logic        push;
  logic [1:0]  push_kind;
  logic [7:0]  push_byte;
  logic [7:0]  bc;
  logic [31:0] win;
  logic [31:0] crc_upd;
  logic [15:0] len_new;
  logic [PCNT_W-1:0] pcnt_inc;
  res_t        push_data;
  res_t        res_q;
  logic        full;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign bc       = inverted_phase ? ~in_byte : in_byte;
  assign win      = {sync_window[23:0], in_byte};
  assign crc_upd  = crc_byte(running_crc, bc);
  assign len_new  = {held_length[7:0], bc};
  assign pcnt_inc = payload_count + PCNT_W'(1);

  always_comb begin
    phase_next          = phase;
    sync_window_next    = sync_window;
    inverted_phase_next = inverted_phase;
    header_count_next   = header_count;
    held_flags_next     = held_flags;
    held_mode_next      = held_mode;
    held_bw_next        = held_bw;
    held_node_next      = held_node;
    held_seq_next       = held_seq;
    held_length_next    = held_length;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    push                = 1'b0;
    push_kind           = KIND_PAYLOAD;
    push_byte           = 8'd0;

    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          sync_window_next = win;
          if (win == SYNC_WORD || win == ~SYNC_WORD) begin
            inverted_phase_next = (win != SYNC_WORD);
            running_crc_next    = SYNC_CRC;
            header_count_next   = 4'd0;
            phase_next          = PH_HEADER;
          end
        end
        PH_HEADER: begin
          running_crc_next  = crc_upd;
          header_count_next = header_count + 4'd1;
          unique case (header_count)
            4'd0: ;
            4'd1: held_flags_next = bc;
            4'd2: held_mode_next  = bc;
            4'd3: held_bw_next    = bc;
            4'd4, 4'd5, 4'd6, 4'd7: held_node_next = {held_node[23:0], bc};
            4'd8, 4'd9, 4'd10, 4'd11: held_seq_next = {held_seq[23:0], bc};
            default: held_length_next = len_new;
          endcase
          if (header_count == HDR_LAST) begin
            header_count_next  = 4'd0;
            payload_count_next = '0;
            received_crc_next  = 24'd0;
            if (len_new > MAX_LEN) begin
              // oversize length: drop the frame silently
              phase_next          = PH_HUNT;
              sync_window_next    = 32'd0;
              inverted_phase_next = 1'b0;
              running_crc_next    = CRC_INIT;
            end else if (len_new == 16'd0) begin
              phase_next = PH_CRC;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_crc_next   = crc_upd;
          payload_count_next = pcnt_inc;
          if (16'(pcnt_inc) >= held_length) begin
            header_count_next = 4'd0;
            phase_next        = PH_CRC;
          end
          push      = 1'b1;
          push_kind = KIND_PAYLOAD;
          push_byte = bc;
        end
        PH_CRC: begin
          if (header_count < 4'd3) begin
            unique case (header_count[1:0])
              2'd0:    received_crc_next[7:0]   = bc;
              2'd1:    received_crc_next[15:8]  = bc;
              default: received_crc_next[23:16] = bc;
            endcase
            header_count_next = header_count + 4'd1;
          end else begin
            push      = 1'b1;
            push_kind = ({bc, received_crc} == ~running_crc) ? KIND_GOOD : KIND_BAD;
            phase_next          = PH_HUNT;
            sync_window_next    = 32'd0;
            inverted_phase_next = 1'b0;
            header_count_next   = 4'd0;
            payload_count_next  = '0;
            running_crc_next    = CRC_INIT;
            received_crc_next   = 24'd0;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_window    <= 32'd0;
      inverted_phase <= 1'b0;
      header_count   <= 4'd0;
      held_flags     <= 8'd0;
      held_mode      <= 8'd0;
      held_bw        <= 8'd0;
      held_node      <= 32'd0;
      held_seq       <= 32'd0;
      held_length    <= 16'd0;
      payload_count  <= '0;
      running_crc    <= CRC_INIT;
      received_crc   <= 24'd0;
    end else begin
      phase          <= phase_next;
      sync_window    <= sync_window_next;
      inverted_phase <= inverted_phase_next;
      header_count   <= header_count_next;
      held_flags     <= held_flags_next;
      held_mode      <= held_mode_next;
      held_bw        <= held_bw_next;
      held_node      <= held_node_next;
      held_seq       <= held_seq_next;
      held_length    <= held_length_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
    end
  end

  always_comb begin
    push_data.kind           = push_kind;
    push_data.out_byte       = push_byte;
    push_data.frame_flags    = held_flags;
    push_data.modulation     = held_mode;
    push_data.bandwidth      = held_bw;
    push_data.node_id        = held_node;
    push_data.sequence_res   = held_seq;
    push_data.payload_length = held_length[10:0];
  end

  shcdf_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_q)
  );

  assign kind           = res_q.kind;
  assign out_byte       = res_q.out_byte;
  assign frame_flags    = res_q.frame_flags;
  assign modulation     = res_q.modulation;
  assign bandwidth      = res_q.bandwidth;
  assign node_id        = res_q.node_id;
  assign sequence_res   = res_q.sequence_res;
  assign payload_length = res_q.payload_length;

endmodule

[rtl/shcdf_checker.sv]
// ----------------------------------------------------------------------------
// shcdf_checker
// Port-level checks on the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module shcdf_checker #(
  parameter int unsigned MAX_PAYLOAD_BYTES = shcdf_pkg::MAX_PAYLOAD_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  out_byte,
  input logic [7:0]  frame_flags,
  input logic [7:0]  modulation,
  input logic [7:0]  bandwidth,
  input logic [31:0] node_id,
  input logic [31:0] sequence_res,
  input logic [10:0] payload_length
);
  import shcdf_pkg::*;

  localparam logic [11:0] MAX_CHK = (MAX_PAYLOAD_BYTES > 2047) ? 12'd2047
                                                               : 12'(MAX_PAYLOAD_BYTES);

  // input only waits when a result word is already queued at the output
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with output empty");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_GOOD || kind == KIND_BAD))
    else $error("illegal result kind");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_PAYLOAD) |-> out_byte == 8'd0)
    else $error("frame end word carries a data byte");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, payload_length} <= MAX_CHK)
    else $error("reported length beyond the maximum");

  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(out_byte)
                                  && $stable(frame_flags) && $stable(modulation)
                                  && $stable(bandwidth) && $stable(node_id)
                                  && $stable(sequence_res) && $stable(payload_length)))
    else $error("stalled result word changed");

endmodule

bind sync_hunt_crc32_deframer_core shcdf_checker #(
  .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
) u_shcdf_checker (.*);
